// ----- rtl/core/random_sphere_fragment_generator_unit_assert.svh -----
// Assertion macros shared by the sphere fragment generator RTL.
// Depends on nothing; included by the top-level module, which carries the assertions.
`ifndef RANDOM_SPHERE_FRAGMENT_GENERATOR_UNIT_ASSERT_SVH
`define RANDOM_SPHERE_FRAGMENT_GENERATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only out of reset.
`define RSFG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rsfg assertion failed");
// Checked at every edge, reset included.
`define RSFG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("rsfg assertion failed");
`else
`define RSFG_ASSERT(lbl, clk, rst_n, prop)
`define RSFG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/rsfg_pkg.sv -----
// Package for the sphere fragment generator: constants, types, small functions.
// Depends on nothing.
package rsfg_pkg;

    localparam int FragmentsMax = 64;
    localparam int DirFracBits  = 14;
    localparam int SqrtSteps    = DirFracBits + 1;
    localparam int RadW         = DirFracBits + 1;
    localparam int CordicSteps  = 16;
    localparam int CordicW      = 22;
    localparam int PhaseW       = 24;
    localparam int AngW         = 22;

    localparam logic [31:0] SeedMix     = 32'h9E3779B9;
    localparam logic [31:0] SeedZeroSub = 32'h853C49E1;
    localparam logic [29:0] CordicGain  = 30'd652032874;
    localparam logic signed [15:0] DirOne = 16'sd16384;

    localparam logic [AngW-1:0] AtanPhase [CordicSteps] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
        22'd166669, 22'd83416, 22'd41718, 22'd20860,
        22'd10430, 22'd5215, 22'd2608, 22'd1304,
        22'd652, 22'd326, 22'd163, 22'd81
    };

    // Register map, indexed by word address.
    typedef enum logic {
        REG_FRAG_COUNT = 1'b0,
        REG_BASE_SPEED = 1'b1
    } t_reg_idx;

    typedef logic [31:0] t_word;

    // One fragment's random draws from the sequencer.
    typedef struct packed {
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] w;
        logic [5:0]  idx;
        logic        last;
    } t_draw;

    // Fields that travel alongside the square root and CORDIC pipelines.
    typedef struct packed {
        logic signed [15:0] dy;
        logic [1:0]         quad;
        logic [AngW-1:0]    ang;
        logic [31:0]        spd_base;
        logic [31:0]        spd_rem;
        logic [5:0]         idx;
        logic               last;
    } t_side;

    // One xorshift32 step.
    function automatic t_word xs32(input t_word s);
        t_word a;
        t_word b;
        a = s ^ (s << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    // floor(n / 65535) for quotients up to 65536.
    function automatic logic [16:0] div_ffff(input logic [31:0] n);
        logic [32:0] sum;
        sum = {1'b0, n} + {17'b0, n[31:16]} + 33'd1;
        return sum[32:16];
    endfunction

    // Fragment count as used: zero reads as one, large values clip.
    function automatic logic [6:0] eff_count(input logic [6:0] c);
        if (c == 7'd0) return 7'd1;
        if (c > 7'(FragmentsMax)) return 7'(FragmentsMax);
        return c;
    endfunction

endpackage

// ----- rtl/core/rsfg_seed_if.sv -----
// Seed channel: valid/ready handshake with a 32-bit seed.
// Depends on nothing.
interface rsfg_seed_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed;
    modport source (output valid, output seed, input ready);
    modport sink (input valid, input seed, output ready);
endinterface

// ----- rtl/core/rsfg_frag_if.sv -----
// Fragment channel: valid/ready handshake with one fragment's fields.
// Depends on nothing.
interface rsfg_frag_if;
    logic        valid;
    logic        ready;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [31:0] speed;
    logic [16:0] mass;
    logic [5:0]  index;
    logic        last;
    modport source (output valid, output dir_x, output dir_y, output dir_z,
                    output speed, output mass, output index, output last, input ready);
    modport sink (input valid, input dir_x, input dir_y, input dir_z,
                  input speed, input mass, input index, input last, output ready);
endinterface

// ----- rtl/core/rsfg_seq.sv -----
// Run sequencer: takes a seed, steps the xorshift32 generator, issues one
// fragment's draws per enabled cycle. Depends on rsfg_pkg and rsfg_seed_if.
module rsfg_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_blocked,
    input  logic [6:0]      i_count,
    rsfg_seed_if.sink       i_seed,
    output logic            o_valid,
    output rsfg_pkg::t_draw o_draw
);
    import rsfg_pkg::*;

    logic        r_active;
    t_word       r_rng;
    logic [5:0]  r_idx;
    logic        r_valid;
    t_draw       r_draw;
    t_word       w_s1;
    t_word       w_s2;
    t_word       w_s3;
    t_word       w_init;
    logic        w_last;

    assign i_seed.ready = !r_active && !i_blocked;

    // Three draws per fragment.
    assign w_s1   = xs32(r_rng);
    assign w_s2   = xs32(w_s1);
    assign w_s3   = xs32(w_s2);
    assign w_init = i_seed.seed ^ SeedMix;
    assign w_last = ({1'b0, r_idx} == (i_count - 7'd1));

    // Run control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (i_seed.valid && i_seed.ready) begin
                r_active <= 1'b1;
            end else if (i_en && r_active && w_last) begin
                r_active <= 1'b0;
            end
            if (i_en) begin
                r_valid <= r_active;
            end
        end
    end

    // Generator state and issued draws.
    always_ff @(posedge i_clk) begin
        if (i_seed.valid && i_seed.ready) begin
            r_rng <= (w_init == '0) ? SeedZeroSub : w_init;
            r_idx <= '0;
        end else if (i_en && r_active) begin
            r_rng <= w_s3;
            r_idx <= r_idx + 6'd1;
        end
        if (i_en && r_active) begin
            r_draw.u    <= w_s1[15:0];
            r_draw.v    <= w_s2[15:0];
            r_draw.w    <= w_s3[15:0];
            r_draw.idx  <= r_idx;
            r_draw.last <= w_last;
        end
    end

    assign o_valid = r_valid;
    assign o_draw  = r_draw;

endmodule

// ----- rtl/core/rsfg_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on rsfg_pkg.
module rsfg_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [29:0]             i_n,
    input  rsfg_pkg::t_side         i_side,
    output logic                    o_valid,
    output logic [rsfg_pkg::RadW-1:0] o_root,
    output rsfg_pkg::t_side         o_side
);
    import rsfg_pkg::*;

    logic        s_v    [0:SqrtSteps];
    logic [29:0] s_n    [0:SqrtSteps];
    logic [29:0] s_res  [0:SqrtSteps];
    t_side       s_side [0:SqrtSteps];

    assign s_v[0]    = i_valid;
    assign s_n[0]    = i_n;
    assign s_res[0]  = '0;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_stage
        localparam logic [29:0] Bit = 30'd1 << (2 * (SqrtSteps - 1 - k));
        logic [29:0] trial;
        logic        ge;

        assign trial = s_res[k] + Bit;
        assign ge    = (s_n[k] >= trial);

        // Stage valid.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[k+1] <= 1'b0;
            end else if (i_en) begin
                s_v[k+1] <= s_v[k];
            end
        end

        // Remainder and partial root.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                s_n[k+1]    <= ge ? (s_n[k] - trial) : s_n[k];
                s_res[k+1]  <= ge ? ((s_res[k] >> 1) + Bit) : (s_res[k] >> 1);
                s_side[k+1] <= s_side[k];
            end
        end
    end

    assign o_valid = s_v[SqrtSteps];
    assign o_root  = s_res[SqrtSteps][RadW-1:0];
    assign o_side  = s_side[SqrtSteps];

endmodule

// ----- rtl/core/rsfg_cordic.sv -----
// Pipelined rotation CORDIC: gain-scaled entry stage, then one
// micro-rotation per stage. Depends on rsfg_pkg.
module rsfg_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [rsfg_pkg::RadW-1:0]       i_radial,
    input  rsfg_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic signed [rsfg_pkg::CordicW-1:0] o_x,
    output logic signed [rsfg_pkg::CordicW-1:0] o_y,
    output rsfg_pkg::t_side                 o_side
);
    import rsfg_pkg::*;

    logic                      s_v    [0:CordicSteps];
    logic signed [CordicW-1:0] s_x    [0:CordicSteps];
    logic signed [CordicW-1:0] s_y    [0:CordicSteps];
    logic signed [23:0]        s_z    [0:CordicSteps];
    t_side                     s_side [0:CordicSteps];
    logic [44:0]               w_prod;
    logic [44:0]               w_x0;

    // Entry: x starts at radial * K with four guard bits.
    assign w_prod = {15'b0, i_radial} * {15'b0, CordicGain};
    assign w_x0   = (w_prod + (45'd1 << 25)) >> 26;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_v[0] <= 1'b0;
        end else if (i_en) begin
            s_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            s_x[0]    <= $signed(w_x0[CordicW-1:0]);
            s_y[0]    <= '0;
            s_z[0]    <= $signed({2'b0, i_side.ang});
            s_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < CordicSteps; k++) begin : g_step
        logic signed [23:0] atan_k;
        assign atan_k = $signed({2'b0, AtanPhase[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[k+1] <= 1'b0;
            end else if (i_en) begin
                s_v[k+1] <= s_v[k];
            end
        end

        // Rotate toward zero residual angle.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!s_z[k][23]) begin
                    s_x[k+1] <= s_x[k] - (s_y[k] >>> k);
                    s_y[k+1] <= s_y[k] + (s_x[k] >>> k);
                    s_z[k+1] <= s_z[k] - atan_k;
                end else begin
                    s_x[k+1] <= s_x[k] + (s_y[k] >>> k);
                    s_y[k+1] <= s_y[k] - (s_x[k] >>> k);
                    s_z[k+1] <= s_z[k] + atan_k;
                end
                s_side[k+1] <= s_side[k];
            end
        end
    end

    assign o_valid = s_v[CordicSteps];
    assign o_x     = s_x[CordicSteps];
    assign o_y     = s_y[CordicSteps];
    assign o_side  = s_side[CordicSteps];

endmodule

// ----- rtl/core/random_sphere_fragment_generator_unit.sv -----
// Top level of the sphere fragment generator: registers, front arithmetic,
// speed path, output stage. Depends on rsfg_pkg, the channel interfaces,
// rsfg_seq, rsfg_sqrt, rsfg_cordic and the assertion header.
//
//   Channel   Dir  Handshake            Carries
//   i_seed    in   valid/ready          32-bit seed, one per run
//   o_frag    out  valid/ready          dir_x/y/z, speed, mass, index, last
//   APB       in   psel/penable/pready  fragment_count (0x0), base_speed (0x4)
//
// A seed starts a run of fragment_count fragments (1 to 64), one issued per
// cycle while o_frag is not stalled, by the three-step xorshift unit; the next
// seed can be taken the cycle after the last fragment of a run is issued.
// A fragment passes these stages after issue: front 2, square root 15,
// CORDIC 17, output 1 stage.
// After a fragment_count write, seeds wait for the mass divider.
// Reset is synchronous and needs no clearing pass; a stall at o_frag
// freezes the whole pipeline, so nothing is lost or repeated.
module random_sphere_fragment_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsfg_seed_if.sink   i_seed,
    rsfg_frag_if.source o_frag,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rsfg_pkg::*;

    `include "random_sphere_fragment_generator_unit_assert.svh"

    logic [6:0]  r_frag_count;
    logic [31:0] r_base_speed;
    logic [6:0]  w_count;
    logic [5:0]  w_last_idx;
    logic        w_en;
    logic        w_cfg_wr;
    t_reg_idx    w_reg;

    // Mass divider.
    logic        r_div_busy;
    logic [4:0]  r_div_cnt;
    logic [6:0]  r_div_d;
    logic [6:0]  r_div_rem;
    logic [16:0] r_div_num;
    logic [16:0] r_mass;
    logic [7:0]  w_div_tmp;
    logic        w_div_ge;
    logic [6:0]  w_wr_count;

    // Sequencer to front.
    logic        w_seq_valid;
    t_draw       w_draw;

    // Front stage two.
    logic               r2_valid;
    logic signed [15:0] r2_dy;
    logic [1:0]         r2_quad;
    logic [AngW-1:0]    r2_ang;
    logic [47:0]        r2_prod;
    logic [5:0]         r2_idx;
    logic               r2_last;
    logic signed [17:0] w_yq;
    logic [16:0]        w_absy;
    logic [31:0]        w_mag;
    logic [16:0]        w_q;
    logic [23:0]        w_pa;
    logic [16:0]        w_pb;
    logic [23:0]        w_phase;

    // Front stage three.
    logic               r3_valid;
    logic [29:0]        r3_rad2;
    t_side              r3_side;
    logic signed [31:0] w_sq;
    logic [48:0]        w_r;
    logic [31:0]        w_hi;
    logic [31:0]        w_t;

    // Pipeline outputs.
    logic                      w_sq_valid;
    logic [RadW-1:0]           w_root;
    t_side                     w_sq_side;
    logic                      w_co_valid;
    logic signed [CordicW-1:0] w_cx;
    logic signed [CordicW-1:0] w_cy;
    t_side                     w_co_side;

    // Output stage.
    logic signed [CordicW-1:0] w_xr;
    logic signed [CordicW-1:0] w_yr;
    logic signed [CordicW-1:0] w_ox;
    logic signed [CordicW-1:0] w_oz;
    logic [16:0]               w_spq;
    logic                      r_out_valid;
    logic [15:0]               r_dir_x;
    logic [15:0]               r_dir_y;
    logic [15:0]               r_dir_z;
    logic [31:0]               r_speed;
    logic [5:0]                r_index;
    logic                      r_last;

    assign w_count    = eff_count(r_frag_count);
    assign w_last_idx = w_count[5:0] - 6'd1;
    assign w_en       = !r_out_valid || o_frag.ready;

    // Configuration port.
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_reg      = t_reg_idx'(paddr[2]);
    assign w_wr_count = eff_count(pwdata[6:0]);

    always_comb begin
        unique case (w_reg)
            REG_FRAG_COUNT: prdata = {25'b0, r_frag_count};
            REG_BASE_SPEED: prdata = r_base_speed;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag_count <= 7'd1;
            r_base_speed <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_FRAG_COUNT: r_frag_count <= pwdata[6:0];
                REG_BASE_SPEED: r_base_speed <= pwdata;
                default:        r_base_speed <= r_base_speed;
            endcase
        end
    end

    // Restoring divider for mass = (65536 + count/2) / count.
    assign w_div_tmp = {r_div_rem, r_div_num[16]};
    assign w_div_ge  = (w_div_tmp >= {1'b0, r_div_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
            r_mass     <= 17'd65536;
        end else if (w_cfg_wr && (w_reg == REG_FRAG_COUNT)) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= 5'd17;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt - 5'd1;
            if (r_div_cnt == 5'd1) begin
                r_div_busy <= 1'b0;
                r_mass     <= {r_div_num[15:0], w_div_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cfg_wr && (w_reg == REG_FRAG_COUNT)) begin
            r_div_d   <= w_wr_count;
            r_div_rem <= '0;
            r_div_num <= 17'd65536 + {11'b0, w_wr_count[6:1]};
        end else if (r_div_busy) begin
            r_div_rem <= w_div_ge ? 7'(w_div_tmp - {1'b0, r_div_d}) : w_div_tmp[6:0];
            r_div_num <= {r_div_num[15:0], w_div_ge};
        end
    end

    rsfg_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_blocked (r_div_busy),
        .i_count   (w_count),
        .i_seed    (i_seed),
        .o_valid   (w_seq_valid),
        .o_draw    (w_draw)
    );

    // Stage two: dir_y, phase and the speed product.
    assign w_yq    = $signed({1'b0, w_draw.u, 1'b0}) - 18'sd65535;
    assign w_absy  = w_yq[17] ? 17'(-w_yq) : w_yq[16:0];
    assign w_mag   = {1'b0, w_absy, 14'b0} + 32'd32767;
    assign w_q     = div_ffff(w_mag);
    assign w_pa    = {w_draw.v, 8'b0};
    assign w_pb    = div_ffff({8'b0, w_pa} + 32'd32767);
    assign w_phase = w_pa + {7'b0, w_pb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= w_seq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dy   <= w_yq[17] ? -$signed(w_q[15:0]) : $signed(w_q[15:0]);
            r2_quad <= w_phase[23:22];
            r2_ang  <= w_phase[AngW-1:0];
            r2_prod <= r_base_speed * {16'b0, w_draw.w};
            r2_idx  <= w_draw.idx;
            r2_last <= w_draw.last;
        end
    end

    // Stage three: radial square and speed split.
    assign w_sq = r2_dy * r2_dy;
    assign w_r  = {1'b0, r2_prod} + (r_base_speed[0] ? 49'd131070 : 49'd65535);
    assign w_hi = w_r[48:17];
    assign w_t  = w_hi + {16'b0, w_r[16:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_rad2          <= 30'(30'd1 << (2 * DirFracBits)) - 30'(w_sq[29:0]);
            r3_side.dy       <= r2_dy;
            r3_side.quad     <= r2_quad;
            r3_side.ang      <= r2_ang;
            r3_side.spd_base <= {1'b0, r_base_speed[31:1]} + w_hi;
            r3_side.spd_rem  <= w_t;
            r3_side.idx      <= r2_idx;
            r3_side.last     <= r2_last;
        end
    end

    rsfg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_valid),
        .i_n     (r3_rad2),
        .i_side  (r3_side),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    rsfg_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_sq_valid),
        .i_radial (w_root),
        .i_side   (w_sq_side),
        .o_valid  (w_co_valid),
        .o_x      (w_cx),
        .o_y      (w_cy),
        .o_side   (w_co_side)
    );

    // Output stage: drop guard bits, place in quadrant, clamp.
    assign w_xr  = (w_cx + 22'sd8) >>> 4;
    assign w_yr  = (w_cy + 22'sd8) >>> 4;
    assign w_spq = div_ffff(w_co_side.spd_rem);

    always_comb begin
        unique case (w_co_side.quad)
            2'd1:    begin w_ox = -w_yr; w_oz = w_xr;  end
            2'd2:    begin w_ox = -w_xr; w_oz = -w_yr; end
            2'd3:    begin w_ox = w_yr;  w_oz = -w_xr; end
            default: begin w_ox = w_xr;  w_oz = w_yr;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_co_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_ox > 22'sd16384) begin
                r_dir_x <= DirOne;
            end else if (w_ox < -22'sd16384) begin
                r_dir_x <= -DirOne;
            end else begin
                r_dir_x <= w_ox[15:0];
            end
            if (w_oz > 22'sd16384) begin
                r_dir_z <= DirOne;
            end else if (w_oz < -22'sd16384) begin
                r_dir_z <= -DirOne;
            end else begin
                r_dir_z <= w_oz[15:0];
            end
            r_dir_y <= w_co_side.dy;
            r_speed <= w_co_side.spd_base + {15'b0, w_spq};
            r_index <= w_co_side.idx;
            r_last  <= w_co_side.last;
        end
    end

    assign o_frag.valid = r_out_valid;
    assign o_frag.dir_x = r_dir_x;
    assign o_frag.dir_y = r_dir_y;
    assign o_frag.dir_z = r_dir_z;
    assign o_frag.speed = r_speed;
    assign o_frag.mass  = r_mass;
    assign o_frag.index = r_index;
    assign o_frag.last  = r_last;

    `RSFG_ASSERT(a_seed_starts_run, i_clk, i_rst_n, i_seed.valid && i_seed.ready |=> !i_seed.ready)
    `RSFG_ASSERT(a_last_index, i_clk, i_rst_n, o_frag.valid && o_frag.last |-> o_frag.index == w_last_idx)
    `RSFG_ASSERT(a_dir_y_range, i_clk, i_rst_n, o_frag.valid |-> ($signed(o_frag.dir_y) <= DirOne) && ($signed(o_frag.dir_y) >= -DirOne))
    `RSFG_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_frag.valid)

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for random_sphere_fragment_generator_unit.
// Depends on rsfg_pkg and the seed and fragment channel interfaces of the RTL.
// Seeds go in under random gaps, fragments are checked against a local predictor.
module tb;
    import rsfg_pkg::*;

    // One expected fragment, at the widths of the output channel.
    typedef struct {
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] dir_z;
        logic [31:0] speed;
        logic [16:0] mass;
        logic [5:0]  index;
        logic        last;
    } t_frag_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rsfg_seed_if seed_ch ();
    rsfg_frag_if frag_ch ();

    random_sphere_fragment_generator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed  (seed_ch),
        .o_frag  (frag_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state and the queues that link the processes.
    logic [6:0]    frag_count_reg = 7'd1;
    logic [31:0]   base_speed_reg = '0;
    logic [31:0]   seed_queue[$];
    t_frag_exp     frag_expect[$];
    int            fail_count = 0;
    bit            no_idle = 1'b0;
    int            send_gap = 0;
    int            recv_stall = 0;

    localparam longint ArcTable [16] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    initial seed_ch.valid = 1'b0;
    initial seed_ch.seed = '0;
    initial frag_ch.ready = 1'b0;

    always #1 i_clk = ~i_clk;

    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 11);
    endfunction

    // Appends one seed to the pending list of the driver.
    function automatic void queue_seed(input logic [31:0] s);
        seed_queue.insert(seed_queue.size(), s);
    endfunction

    function automatic logic [31:0] xorshift_next(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        return t ^ (t << 5);
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Expands one seed into the whole run of fragments it should produce.
    function automatic void predict_fragments(input logic [31:0] seed);
        int              count;
        longint unsigned mass;
        logic [31:0]     rng;
        logic [15:0]     u, v, w;
        longint          yq, dy, x, y, z, cx, cz, dxs, dys;
        longint unsigned mag, radial, phase, spd;
        logic [1:0]      quad;
        t_frag_exp       e;
        count = frag_count_reg;
        if (count == 0) count = 1;
        if (count > FragmentsMax) count = FragmentsMax;
        mass = (65536 + count / 2) / count;
        rng = seed ^ SeedMix;
        if (rng == 0) rng = SeedZeroSub;
        for (int i = 0; i < count; i++) begin
            rng = xorshift_next(rng); u = rng[15:0];
            rng = xorshift_next(rng); v = rng[15:0];
            rng = xorshift_next(rng); w = rng[15:0];
            // Vertical component from u, rounded to nearest.
            yq = 2 * longint'(u) - 65535;
            mag = longint'(yq < 0 ? -yq : yq) << 14;
            dy = longint'((mag + 32767) / 65535);
            if (yq < 0) dy = -dy;
            dy = clamp_unit(dy);
            radial = int_sqrt((64'd1 << 28) - longint'(dy * dy));
            // Angle from v: quadrant and residual for the rotation.
            phase = ((longint'(v) << 24) + 32767) / 65535;
            phase &= 64'hFF_FFFF;
            quad = phase[23:22];
            z = longint'(phase & 64'h3F_FFFF);
            x = longint'((radial * 652032874 + (64'd1 << 25)) >> 26);
            y = 0;
            for (int k = 0; k < 16; k++) begin
                dxs = y >>> k;
                dys = x >>> k;
                if (z >= 0) begin
                    x -= dxs; y += dys; z -= ArcTable[k];
                end else begin
                    x += dxs; y -= dys; z += ArcTable[k];
                end
            end
            x = (x + 8) >>> 4;
            y = (y + 8) >>> 4;
            case (quad)
                2'd1: begin cx = -y; cz = x; end
                2'd2: begin cx = -x; cz = -y; end
                2'd3: begin cx = y; cz = -x; end
                default: begin cx = x; cz = y; end
            endcase
            spd = (longint'(base_speed_reg) * (65535 + longint'(w)) + 65535) / 131070;
            if (spd > 64'hFFFF_FFFF) spd = 64'hFFFF_FFFF;
            e.dir_x = 16'(clamp_unit(cx));
            e.dir_y = 16'(dy);
            e.dir_z = 16'(clamp_unit(cz));
            e.speed = spd[31:0];
            e.mass = mass[16:0];
            e.index = 6'(i);
            e.last = (i + 1 == count);
            frag_expect.insert(frag_expect.size(), e);
        end
    endfunction

    // Seed driver: takes the next pending seed after a random gap.
    always @(posedge i_clk) begin
        logic nv;
        nv = seed_ch.valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (seed_ch.valid && seed_ch.ready) begin
                predict_fragments(seed_ch.seed);
                nv = 1'b0;
                send_gap = draw_wait();
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (seed_queue.size() > 0) begin
                    seed_ch.seed <= seed_queue.pop_front();
                    nv = 1'b1;
                end
            end
        end
        seed_ch.valid <= nv;
    end

    // Fragment monitor: compares each transaction with the oldest expectation.
    always @(posedge i_clk) begin
        logic      nr;
        t_frag_exp e;
        nr = 1'b0;
        if (i_rst_n) begin
            if (frag_ch.valid && frag_ch.ready) begin
                if (frag_expect.size() == 0) begin
                    $error("unexpected fragment, index %0d", frag_ch.index);
                    fail_count++;
                end else begin
                    e = frag_expect.pop_front();
                    if (frag_ch.dir_x !== e.dir_x) begin
                        $error("dir_x: expected %h, got %h", e.dir_x, frag_ch.dir_x);
                        fail_count++;
                    end
                    if (frag_ch.dir_y !== e.dir_y) begin
                        $error("dir_y: expected %h, got %h", e.dir_y, frag_ch.dir_y);
                        fail_count++;
                    end
                    if (frag_ch.dir_z !== e.dir_z) begin
                        $error("dir_z: expected %h, got %h", e.dir_z, frag_ch.dir_z);
                        fail_count++;
                    end
                    if (frag_ch.speed !== e.speed) begin
                        $error("speed: expected %h, got %h", e.speed, frag_ch.speed);
                        fail_count++;
                    end
                    if (frag_ch.mass !== e.mass) begin
                        $error("mass: expected %h, got %h", e.mass, frag_ch.mass);
                        fail_count++;
                    end
                    if (frag_ch.index !== e.index) begin
                        $error("index: expected %0d, got %0d", e.index, frag_ch.index);
                        fail_count++;
                    end
                    if (frag_ch.last !== e.last) begin
                        $error("last: expected %b, got %b", e.last, frag_ch.last);
                        fail_count++;
                    end
                end
                recv_stall = draw_wait();
            end
            if (recv_stall > 0) begin
                recv_stall--;
            end else begin
                nr = 1'b1;
            end
        end
        frag_ch.ready <= nr;
    end

    // Register write: setup cycle, then access cycle.
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_FRAG_COUNT) frag_count_reg = data[6:0];
        else base_speed_reg = data;
    endtask

    // Waits until every seed is taken and every fragment has come back.
    task automatic wait_idle();
        while (seed_queue.size() > 0 || seed_ch.valid || frag_expect.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [6:0] cnt, input logic [31:0] spd, input int n);
        wait_idle();
        reg_write(REG_FRAG_COUNT, {25'd0, cnt});
        reg_write(REG_BASE_SPEED, spd);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) queue_seed($urandom());
    endtask

    // Stimulus: directed seeds and counts first, then random phases.
    initial begin
        logic [6:0]  cnt;
        logic [31:0] spd;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Reset settings; seed that mixes to zero, and the extremes of the seed.
        queue_seed(SeedMix);
        queue_seed(32'h0000_0000);
        queue_seed(32'hFFFF_FFFF);
        queue_seed(32'hAAAA_AAAA);
        queue_seed(32'h5555_5555);
        run_phase(7'd0, 32'hFFFF_FFFF, 0);
        queue_seed(SeedMix);
        queue_seed(32'h1234_5678);
        run_phase(7'd64, 32'h0001_0000, 3);
        run_phase(7'd127, 32'd0, 2);
        run_phase(7'd65, 32'hFFFF_FFFF, 2);
        run_phase(7'd1, 32'h8000_0000, 8);
        for (int i = 0; i < 6; i++) queue_seed(32'd1 << (i * 5 + 1));
        // Random phases, mostly short runs with a few at the maximum.
        for (int p = 0; p < 14; p++) begin
            case ($urandom_range(0, 7))
                0: cnt = 7'd64;
                1: cnt = 7'($urandom_range(65, 127));
                2: cnt = 7'd0;
                default: cnt = 7'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 3))
                0: spd = 32'd0;
                1: spd = 32'hFFFF_FFFF;
                default: spd = $urandom();
            endcase
            run_phase(cnt, spd, 11);
        end
        wait_idle();
        if (fail_count == 0) begin
            $display("PASS random_sphere_fragment_generator_unit");
        end else begin
            $display("FAIL random_sphere_fragment_generator_unit");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4000000;
        $display("FAIL random_sphere_fragment_generator_unit");
        $finish;
    end
endmodule
